// File: sv/pfoi_pkg.sv
// Shared constants, types and status codes for the palette find-or-insert core.
package pfoi_pkg;

    localparam int MAX_COLORS = 256;
    localparam int IDX_W      = (MAX_COLORS > 2) ? $clog2(MAX_COLORS) : 1;
    localparam int CNT_W      = $clog2(MAX_COLORS + 1);
    localparam int COLOR_W    = 24;

    localparam logic [1:0] ST_PRESENT = 2'd0;
    localparam logic [1:0] ST_NEW     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // One pixel word as it travels down the cell chain.
    typedef struct packed {
        logic                 valid;
        logic                 sof;
        logic [COLOR_W-1:0]   color;
        logic                 done;    // matched or stored somewhere upstream
        logic [1:0]           status;
        logic [IDX_W-1:0]     idx;
        logic [CNT_W-1:0]     count;   // used entries seen so far
    } pix_t;

endpackage

// File: sv/palette_find_or_insert_core.sv
// Top level of the palette find-or-insert core: input stage, cell chain, output register.
//
// Pixels enter at one word per clock and flow through a chain of MAX_COLORS
// cells (256), each cell holding one palette entry and comparing, storing or
// clearing as the pixel passes, so the palette is searched one entry per
// stage. Throughput is one pixel per cycle while results are taken; each pixel
// passes all MAX_COLORS cells and then the output register. The whole chain
// stalls while a result waits in the output register and is not taken.
// start_of_image empties the palette before its own pixel is handled. Each
// result carries the index, the status (0 present, 1 new, 2 full and dropped)
// and the count of entries in use after that pixel.
module palette_find_or_insert_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tuser,   // start_of_image [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // color_index [7:0], status [9:8], colors_in_use [18:10]
);
    import pfoi_pkg::*;

    logic adv;
    pix_t link [0:MAX_COLORS];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        link[0].valid  = s_tvalid;
        link[0].sof    = s_tuser;
        link[0].color  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        link[0].done   = 1'b0;
        link[0].status = ST_PRESENT;
        link[0].idx    = '0;
        link[0].count  = '0;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_COLORS; g = g + 1)
        begin : g_cell
            pfoi_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .pix_in  (link[g]),
                .pix_out (link[g+1])
            );
        end
    endgenerate

    pfoi_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .pix_in   (link[MAX_COLORS]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/pfoi_cell.sv
// One palette cell: holds one entry and a pipeline stage for the passing pixel.
module pfoi_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  pfoi_pkg::pix_t pix_in,
    output pfoi_pkg::pix_t pix_out
);
    import pfoi_pkg::*;

    logic [COLOR_W-1:0] entry_reg;
    logic               used_reg;
    logic               used_eff;
    logic               hit;
    logic               claim;
    logic               valid_reg;
    pix_t               stage_reg;
    pix_t               stage_next;

    // A start-of-image pixel clears each cell as it passes; pixels ahead are unaffected.
    assign used_eff = used_reg && !(pix_in.valid && pix_in.sof);
    assign hit      = pix_in.valid && !pix_in.done && used_eff && (entry_reg == pix_in.color);
    assign claim    = pix_in.valid && !pix_in.done && !used_eff;

    always_comb
    begin
        stage_next = pix_in;
        if (hit)
        begin
            stage_next.done   = 1'b1;
            stage_next.status = ST_PRESENT;
            stage_next.idx    = pix_in.count[IDX_W-1:0];
        end
        else if (claim)
        begin
            stage_next.done   = 1'b1;
            stage_next.status = ST_NEW;
            stage_next.idx    = pix_in.count[IDX_W-1:0];
        end
        // entries fill from cell 0 up, so counting used cells gives the fill level
        if (used_eff || claim)
        begin
            stage_next.count = pix_in.count + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= pix_in.valid;
            if (pix_in.valid)
            begin
                used_reg <= used_eff || claim;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
            if (claim)
            begin
                entry_reg <= pix_in.color;
            end
        end
    end

    always_comb
    begin
        pix_out       = stage_reg;
        pix_out.valid = valid_reg;
    end

endmodule

// File: sv/pfoi_out.sv
// Output register: turns the word leaving the chain into a result word.
module pfoi_out
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  pfoi_pkg::pix_t pix_in,
    output logic           m_tvalid,
    output logic [23:0]    m_tdata
);
    import pfoi_pkg::*;

    logic        valid_reg;
    logic [23:0] data_reg;
    logic [23:0] data_next;
    logic [31:0] idx_wide;
    logic [31:0] cnt_wide;
    logic [1:0]  status;
    logic [7:0]  index;

    assign idx_wide = 32'(pix_in.idx);
    assign cnt_wide = 32'(pix_in.count);

    // no match and no free cell anywhere: palette full, pixel dropped
    assign status = pix_in.done ? pix_in.status : ST_FULL;
    assign index  = pix_in.done ? idx_wide[7:0] : 8'd0;

    assign data_next = {5'd0, cnt_wide[8:0], status, index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: tb/palette_find_or_insert_core_tb.sv
// Self-checking testbench for the palette find-or-insert core: tests, driver, monitor, predictor.
`timescale 1ns / 100ps

module palette_find_or_insert_core_tb;
    import pfoi_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int LATENCY       = MAX_COLORS + 1;
    localparam int TARGET_PIXELS = 1800;
    localparam int TAIL_PIXELS   = 150;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int POOL_MAX      = 320;

    typedef struct {
        logic [7:0] color_index;
        logic [1:0] status;
        logic [8:0] colors_in_use;
    } palette_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic        s_tuser;   // start_of_image [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // color_index [7:0], status [9:8], colors_in_use [18:10]

    // predictor copy of the palette
    logic [23:0] pal_colors [0:MAX_COLORS-1];
    int          pal_count;

    palette_result_t result_q [$];
    int              errors;
    int              pixels_sent;
    bit              idle_on;
    int              hold_left;
    int              stall_left;
    logic [23:0]     pool [0:POOL_MAX-1];

    palette_find_or_insert_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #(CLK_HALF_NS);
        clk = 1'b0;
        #(CLK_HALF_NS);
    end

    function automatic palette_result_t lookup_or_append(input bit sof, input logic [23:0] rgb);
        palette_result_t r;
        int hit;
        hit = -1;
        if (sof)
            pal_count = 0;
        for (int k = 0; k < pal_count; k++)
        begin
            if (hit < 0 && pal_colors[k] == rgb)
                hit = k;
        end
        if (hit >= 0)
        begin
            r.color_index = hit[7:0];
            r.status      = ST_PRESENT;
        end
        else if (pal_count < MAX_COLORS)
        begin
            pal_colors[pal_count] = rgb;
            r.color_index = pal_count[7:0];
            r.status      = ST_NEW;
            pal_count++;
        end
        else
        begin
            r.color_index = 8'd0;
            r.status      = ST_FULL;
        end
        r.colors_in_use = pal_count[8:0];
        return r;
    endfunction

    function automatic logic [23:0] rand_rgb();
        return 24'($urandom());
    endfunction

    // rgb is {red, green, blue}
    task automatic send_pixel(input bit sof, input logic [23:0] rgb);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sof;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        result_q.push_back(lookup_or_append(sof, rgb));
        pixels_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        wait (result_q.size() == 0);
        @(posedge clk);
    endtask

    // Receiver: a long hold-off while hold_left is set, else random stall bursts when idling is on.
    initial
    begin
        bit rdy;
        m_tready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        palette_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected result word 0x%06h", m_tdata);
                errors++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (m_tdata[7:0] !== exp_r.color_index)
                begin
                    $error("color_index: expected %0d, got %0d", exp_r.color_index, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[9:8] !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[9:8]);
                    errors++;
                end
                if (m_tdata[18:10] !== exp_r.colors_in_use)
                begin
                    $error("colors_in_use: expected %0d, got %0d",
                           exp_r.colors_in_use, m_tdata[18:10]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        // no mark after reset: count starts at zero anyway
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFF0000);
        send_pixel(1'b0, 24'h00FF00);
        send_pixel(1'b0, 24'h0000FF);
        send_pixel(1'b0, 24'h000001);
        send_pixel(1'b0, 24'h800000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h0000FF);
        // mark on a color that was stored before: it becomes entry 0
        send_pixel(1'b1, 24'h0000FF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'h0000FF);
        send_pixel(1'b1, 24'h000000);
        send_pixel(1'b1, 24'h000000);
        send_pixel(1'b0, 24'h7F7F7F);
        wait_results_done();
    endtask

    task automatic test_palette_full();
        logic [23:0] c;
        send_pixel(1'b1, rand_rgb());
        while (pal_count < MAX_COLORS)
            send_pixel(1'b0, rand_rgb());
        for (int i = 0; i < 12; i++)
        begin
            c = rand_rgb();
            send_pixel(1'b0, c);
            send_pixel(1'b0, pal_colors[$urandom_range(0, MAX_COLORS - 1)]);
        end
        send_pixel(1'b0, pal_colors[MAX_COLORS - 1]);
        send_pixel(1'b0, pal_colors[0]);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        // mark while full: pixel lands at entry 0
        send_pixel(1'b1, rand_rgb());
        send_pixel(1'b0, rand_rgb());
        wait_results_done();
    endtask

    task automatic send_image(input int len, input int pool_size);
        for (int i = 0; i < pool_size; i++)
            pool[i] = rand_rgb();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                send_pixel(i == 0, pool[$urandom_range(0, pool_size - 1)]);
            else if ($urandom_range(0, 9) == 0)
                send_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
            else
                send_pixel(i == 0 && $urandom_range(0, 9) != 0, rand_rgb());
        end
    endtask

    task automatic test_output_hold();
        hold_left = 700;
        send_image(400, 24);
        wait_results_done();
    endtask

    task automatic test_random_images();
        while (pixels_sent < TARGET_PIXELS - TAIL_PIXELS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 14) == 0)
                send_image($urandom_range(260, 330), POOL_MAX);
            else
                send_image($urandom_range(1, 80), $urandom_range(1, 48));
        end
        idle_on = 1'b1;
        wait_results_done();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        // at least one image with no idling, even when the random part ran long
        do
            send_image($urandom_range(10, 60), $urandom_range(1, 32));
        while (pixels_sent < TARGET_PIXELS);
        wait_results_done();
    endtask

    initial
    begin
        errors      = 0;
        pixels_sent = 0;
        pal_count   = 0;
        idle_on     = 1'b1;
        hold_left   = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_palette_full();
        test_output_hold();
        test_random_images();
        test_quiet_tail();

        repeat (LATENCY + 16) @(posedge clk);
        if (errors == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/pfoi_pkg.sv
sv/pfoi_cell.sv
sv/pfoi_out.sv
sv/palette_find_or_insert_core.sv
tb/palette_find_or_insert_core_tb.sv
